// ===== design/rnp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rnp_pkg
// Shared types and constants of the RTP NAL-unit packetizer.
// ----------------------------------------------------------------------------
package rnp_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_IDX_SSRC        = 2'd0;
    localparam logic [1:0] CFG_IDX_HEVC_MODE   = 2'd1;
    localparam logic [1:0] CFG_IDX_MAX_PAYLOAD = 2'd2;

    localparam logic [11:0] RESET_MAX_PAYLOAD = 12'd1400;
    localparam logic [11:0] MIN_PAYLOAD       = 12'd16;

    // RTP fixed header bytes
    localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
    localparam logic [7:0] RTP_PAYLOAD_TYPE = 8'd97;

    // fragmentation header pieces
    localparam logic [7:0] H264_NRI_MASK  = 8'hE0;
    localparam logic [7:0] H264_FU_TYPE   = 8'd28;
    localparam logic [7:0] H264_TYPE_MASK = 8'h1F;
    localparam logic [7:0] H265_KEEP_MASK = 8'h81;
    localparam logic [7:0] H265_FU_TYPE   = 8'd49;
    localparam logic [7:0] H265_TYPE_MASK = 8'h3F;
    localparam logic [7:0] FU_START_BIT   = 8'h80;
    localparam logic [7:0] FU_END_BIT     = 8'h40;

    // output slots of one job: 0..11 RTP header, 12..14 FU bytes, 15 data
    localparam logic [3:0] SLOT_FIRST    = 4'd0;
    localparam logic [3:0] SLOT_LAST_RTP = 4'd11;
    localparam logic [3:0] SLOT_DATA     = 4'd15;

    typedef struct packed {
        logic [31:0] ssrc;
        logic        hevc_mode;
        logic [11:0] max_payload;
    } cfg_t;

    // one classified input byte, handed from front to back
    typedef struct packed {
        logic [7:0]  data;
        logic        pkt_end;
        logic        has_rtp;
        logic [1:0]  fu_cnt;   // FU bytes, right-aligned on slot 14
        logic [7:0]  fu0;      // slot 12
        logic [7:0]  fu1;      // slot 13
        logic [7:0]  fu2;      // slot 14
        logic [15:0] seq;
        logic [31:0] ts;
    } job_t;

endpackage
`default_nettype wire

// ===== design/rnp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rnp_front
// Accepts NAL bytes, tracks unit and fragment state, and turns each byte but
// the NAL header of a fragmented unit into a job describing its packet bytes.
// ----------------------------------------------------------------------------
module rnp_front #(
    parameter int LENGTH_BITS = 24
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  rnp_pkg::cfg_t       cfg,
    input  wire                 accept,
    input  wire  [7:0]          nal_byte,
    input  wire                 start_of_unit,
    input  wire  [23:0]         unit_length,
    input  wire  [31:0]         rtp_timestamp,
    output logic                push,
    output rnp_pkg::job_t       job
);
    import rnp_pkg::*;

    logic [15:0]            seq_reg, seq_next;
    logic [LENGTH_BITS-1:0] pos_reg, pos_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [31:0]            ts_reg, ts_next;
    logic [7:0]             hdr0_reg, hdr0_next;
    logic [7:0]             hdr1_reg, hdr1_next;
    logic [11:0]            chunk_reg, chunk_next;
    logic                   frag_reg, frag_next;
    logic                   first_reg, first_next;

    logic [11:0]            maxp;
    logic [LENGTH_BITS-1:0] maxp_l;
    logic [LENGTH_BITS-1:0] len_in;
    logic [LENGTH_BITS-1:0] eff_pos;
    logic [11:0]            eff_chunk;
    logic                   eff_first;
    logic                   active;
    logic                   last_byte;
    logic                   last_frag;
    logic                   in_hdr;
    logic [11:0]            chunk_inc;
    logic                   job_valid;
    logic [7:0]             fu_hdr;

    // effective limit and length
    assign maxp   = (cfg.max_payload < MIN_PAYLOAD) ? MIN_PAYLOAD : cfg.max_payload;
    assign maxp_l = LENGTH_BITS'(maxp);
    assign len_in = LENGTH_BITS'({8'd0, unit_length});

    // classify the byte and work out the next state
    always_comb
    begin
        len_next   = start_of_unit ? len_in : len_reg;
        ts_next    = start_of_unit ? rtp_timestamp : ts_reg;
        frag_next  = start_of_unit ? (len_in > maxp_l) : frag_reg;
        eff_pos    = start_of_unit ? '0 : pos_reg;
        eff_chunk  = start_of_unit ? 12'd0 : chunk_reg;
        eff_first  = start_of_unit ? 1'b1 : first_reg;

        active     = eff_pos < len_next;
        last_byte  = eff_pos == (len_next - LENGTH_BITS'(1));
        last_frag  = (len_next - eff_pos) <= maxp_l;
        in_hdr     = (eff_pos == '0) ||
                     (cfg.hevc_mode && (eff_pos == LENGTH_BITS'(1)));
        chunk_inc  = eff_chunk + 12'd1;

        pos_next   = eff_pos;
        chunk_next = eff_chunk;
        first_next = eff_first;
        seq_next   = seq_reg;
        hdr0_next  = hdr0_reg;
        hdr1_next  = hdr1_reg;
        job_valid  = 1'b0;
        fu_hdr     = 8'd0;

        job         = '0;
        job.data    = nal_byte;
        job.seq     = seq_reg;
        job.ts      = ts_next;

        if (active)
        begin
            pos_next = eff_pos + LENGTH_BITS'(1);
            if (eff_pos == '0)
                hdr0_next = nal_byte;
            if (eff_pos == LENGTH_BITS'(1))
                hdr1_next = nal_byte;

            if (!frag_next)
            begin
                // single packet per unit
                job_valid   = 1'b1;
                job.pkt_end = last_byte;
                job.has_rtp = (eff_pos == '0);
                if (eff_pos == '0)
                    seq_next = seq_reg + 16'd1;
            end
            else if (!in_hdr)
            begin
                job_valid = 1'b1;
                if (eff_chunk == 12'd0)
                begin
                    // packet opens: RTP header plus FU bytes
                    job.has_rtp = 1'b1;
                    seq_next    = seq_reg + 16'd1;
                    first_next  = 1'b0;
                    if (cfg.hevc_mode)
                    begin
                        job.fu_cnt = 2'd3;
                        job.fu0    = (hdr0_reg & H265_KEEP_MASK) | (H265_FU_TYPE << 1);
                        job.fu1    = hdr1_reg;
                        fu_hdr     = (hdr0_reg >> 1) & H265_TYPE_MASK;
                    end
                    else
                    begin
                        job.fu_cnt = 2'd2;
                        job.fu1    = (hdr0_reg & H264_NRI_MASK) | H264_FU_TYPE;
                        fu_hdr     = hdr0_reg & H264_TYPE_MASK;
                    end
                    if (eff_first)
                        fu_hdr = fu_hdr | FU_START_BIT;
                    if (last_frag)
                        fu_hdr = fu_hdr | FU_END_BIT;
                    job.fu2 = fu_hdr;
                end
                if (last_byte || (chunk_inc >= maxp))
                begin
                    job.pkt_end = 1'b1;
                    chunk_next  = 12'd0;
                end
                else
                begin
                    chunk_next  = chunk_inc;
                end
            end
        end
    end

    assign push = accept && job_valid;

    // unit state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg   <= 16'd0;
            pos_reg   <= '0;
            len_reg   <= '0;
            ts_reg    <= 32'd0;
            hdr0_reg  <= 8'd0;
            hdr1_reg  <= 8'd0;
            chunk_reg <= 12'd0;
            frag_reg  <= 1'b0;
            first_reg <= 1'b1;
        end
        else if (accept)
        begin
            seq_reg   <= seq_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            ts_reg    <= ts_next;
            hdr0_reg  <= hdr0_next;
            hdr1_reg  <= hdr1_next;
            chunk_reg <= chunk_next;
            frag_reg  <= frag_next;
            first_reg <= first_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/rnp_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rnp_fifo
// Short job queue between front and back, head readable at once.
// ----------------------------------------------------------------------------
module rnp_fifo #(
    parameter int DEPTH = 4
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            push,
    input  rnp_pkg::job_t  push_job,
    input  wire            pop,
    output logic           full,
    output logic           head_valid,
    output rnp_pkg::job_t  head_job
);
    import rnp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = mem_reg[rd_ptr_reg];

    // pointer and fill tracking
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule
`default_nettype wire

// ===== design/rnp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rnp_back
// Walks the slots of the head job and drives one packet byte per cycle,
// while the receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module rnp_back (
    input  wire            clk,
    input  wire            rst_n,
    input  wire  [31:0]    ssrc,
    input  wire            head_valid,
    input  rnp_pkg::job_t  head_job,
    output logic           pop,
    output logic           out_valid,
    input  wire            out_ready,
    output logic [7:0]     out_byte,
    output logic           out_packet_end,
    output logic           out_run_end
);
    import rnp_pkg::*;

    logic [3:0] slot_reg, slot_next;
    logic       started_reg, started_next;
    logic [3:0] slot;
    logic       advance;
    logic       emit;
    logic [7:0] slot_byte;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] byte_reg;
    logic       pkt_end_reg;
    logic       run_end_reg;

    // a fresh job starts at its first present slot
    assign slot    = started_reg ? slot_reg : (head_job.has_rtp ? SLOT_FIRST : SLOT_DATA);
    assign advance = !out_valid_reg || out_ready;
    assign emit    = advance && head_valid;
    assign pop     = emit && (slot == SLOT_DATA);

    // slot byte select
    always_comb
    begin
        case (slot)
            4'd0:    slot_byte = RTP_VERSION_BYTE;
            4'd1:    slot_byte = RTP_PAYLOAD_TYPE;
            4'd2:    slot_byte = head_job.seq[15:8];
            4'd3:    slot_byte = head_job.seq[7:0];
            4'd4:    slot_byte = head_job.ts[31:24];
            4'd5:    slot_byte = head_job.ts[23:16];
            4'd6:    slot_byte = head_job.ts[15:8];
            4'd7:    slot_byte = head_job.ts[7:0];
            4'd8:    slot_byte = ssrc[31:24];
            4'd9:    slot_byte = ssrc[23:16];
            4'd10:   slot_byte = ssrc[15:8];
            4'd11:   slot_byte = ssrc[7:0];
            4'd12:   slot_byte = head_job.fu0;
            4'd13:   slot_byte = head_job.fu1;
            4'd14:   slot_byte = head_job.fu2;
            default: slot_byte = head_job.data;
        endcase
    end

    // slot sequencing; FU bytes sit right-aligned before the data slot
    always_comb
    begin
        slot_next    = slot_reg;
        started_next = started_reg;
        if (emit)
        begin
            if (slot == SLOT_DATA)
            begin
                started_next = 1'b0;
            end
            else
            begin
                started_next = 1'b1;
                if (slot == SLOT_LAST_RTP)
                    slot_next = SLOT_DATA - {2'b00, head_job.fu_cnt};
                else
                    slot_next = slot + 4'd1;
            end
        end
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= SLOT_FIRST;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg      <= slot_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_reg    <= slot_byte;
            pkt_end_reg <= (slot == SLOT_DATA) && head_job.pkt_end;
            run_end_reg <= (slot == SLOT_DATA);
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = byte_reg;
    assign out_packet_end = pkt_end_reg;
    assign out_run_end    = run_end_reg;

    // checks
    a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("job popped from empty queue");

    a_started_keeps_head: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |-> head_valid)
        else $error("job vanished while being emitted");

    a_end_on_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && pkt_end_reg) |-> run_end_reg)
        else $error("packet end outside data slot");

    a_header_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (slot != SLOT_DATA) && (slot != SLOT_LAST_RTP)) |=> (slot_reg == $past(slot) + 4'd1))
        else $error("slot sequence skipped");

endmodule
`default_nettype wire

// ===== design/rtp_nal_packetizer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rtp_nal_packetizer_core
// RTP packetizer for H.264 / H.265 NAL units with FU fragmentation.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one NAL byte per request; tuser marks the first byte of a
//   unit, which also samples the unit length and the RTP timestamp.
//   m_axis carries packet bytes; tlast marks the final byte of a packet and
//   tuser the last byte caused by one input byte.
//   cfg writes ssrc (0), hevc_mode (1) and max_payload (2); write only while
//   the block is idle.  cfg_ready is always high.
// Timing:
//   The first packet byte of a request passes through the job queue and then
//   the output register.  The back end emits one byte per cycle while the
//   receiver is ready, so a byte that opens a packet also costs its RTP header
//   bytes and, in an H.264/H.265 fragment, its two/three FU bytes.  A job queue of
//   QUEUE_DEPTH entries absorbs these bursts; s_axis_tready drops only while
//   that queue is full.
// Reset clears all unit state, the sequence number and the queue; max_payload
//   returns to 1400.  When the receiver stalls, the output register holds its
//   byte, the queue fills, and then input requests are held off.
// ----------------------------------------------------------------------------
module rtp_nal_packetizer_core #(
    parameter int LENGTH_BITS = 24,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire         clk,
    input  wire         rst_n,
    // input stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,   // nal_byte[7:0], unit_length[31:8], rtp_timestamp[63:32]
    input  wire         s_axis_tuser,   // start_of_unit
    // output stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // packet_byte[7:0]
    output logic        m_axis_tlast,   // packet_end
    output logic        m_axis_tuser,   // run_end
    // configuration writes
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [31:0] cfg_data
);
    import rnp_pkg::*;

    cfg_t  cfg_reg;
    logic  accept;
    logic  push;
    job_t  push_job;
    logic  pop;
    logic  full;
    logic  head_valid;
    job_t  head_job;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ssrc        <= 32'd0;
            cfg_reg.hevc_mode   <= 1'b0;
            cfg_reg.max_payload <= RESET_MAX_PAYLOAD;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_IDX_SSRC:        cfg_reg.ssrc        <= cfg_data;
                CFG_IDX_HEVC_MODE:   cfg_reg.hevc_mode   <= cfg_data[0];
                CFG_IDX_MAX_PAYLOAD: cfg_reg.max_payload <= cfg_data[11:0];
                default:             ;
            endcase
        end
    end

    // input handshake
    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && !full;

    rnp_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .accept        (accept),
        .nal_byte      (s_axis_tdata[7:0]),
        .start_of_unit (s_axis_tuser),
        .unit_length   (s_axis_tdata[31:8]),
        .rtp_timestamp (s_axis_tdata[63:32]),
        .push          (push),
        .job           (push_job)
    );

    rnp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    rnp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .ssrc           (cfg_reg.ssrc),
        .head_valid     (head_valid),
        .head_job       (head_job),
        .pop            (pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_byte       (m_axis_tdata),
        .out_packet_end (m_axis_tlast),
        .out_run_end    (m_axis_tuser)
    );

endmodule
`default_nettype wire
